/* rtl/iotb_pkg.sv */
// Shared types, constants and helpers for the indent outline tree builder.
`timescale 1ns / 1ps

package iotb_pkg;

  // Table and field sizes
  localparam int MAX_NODES  = 1024;
  localparam int MAX_DEPTH  = 31;
  localparam int LABEL_MAX  = 4095;
  localparam int STACK_SIZE = MAX_DEPTH + 1;

  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int DEPTH_W = 5;
  localparam int LABEL_W = 12;
  localparam int FILL_W  = 6;
  localparam int SADDR_W = 5;
  localparam int BW_W    = 17;
  localparam int PX_W    = 15;
  localparam int PY_W    = 18;
  localparam int MUL_A_W = 12;
  localparam int MUL_B_W = 10;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Special bytes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_HSPACE = 3'd0;
  localparam logic [2:0] REG_VSPACE = 3'd1;
  localparam logic [2:0] REG_MARGIN = 3'd2;
  localparam logic [2:0] REG_MINBW  = 3'd3;
  localparam logic [2:0] REG_CHARW  = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_CMP,
    ST_MUL_BW,
    ST_MUL_PX,
    ST_MUL_PY,
    ST_DONE
  } iotb_state_t;

  // What the line decoder reports for the byte on the input
  typedef struct packed {
    logic                 line_end;
    logic                 node_found;
    logic [LABEL_W-1:0]   label;
    logic [DEPTH_W-1:0]   depth;
  } line_evt_t;

  // One stack entry: depth of a node and its index
  typedef struct packed {
    logic [DEPTH_W-1:0] level;
    logic [IDX_W-1:0]   node;
  } stk_entry_t;

  // Stack memory control from the sequencer
  typedef struct packed {
    logic               rd_en;
    logic [SADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [SADDR_W-1:0] wr_addr;
    stk_entry_t         wr_entry;
  } stk_ctrl_t;

endpackage

/* rtl/indent_outline_tree_builder.sv */
// Top level: outline tree builder sequencer, configuration and output register.
//
// Input channel in_*: one source byte per word (in_ch, in_last_byte) under
// in_valid/in_ready. Output channel out_*: at most one result word per input
// word, under out_valid/out_ready. Configuration is an APB-style port
// (psel, penable, pwrite, paddr, pwdata, prdata, pready), registers at 4*i.
// A byte that does not end a node line, and is not the final byte, is taken
// while the sequencer stays idle. A byte that ends a line with a node runs
// the stack read loop, popping entries that are not shallower, and then
// three passes through the single shared multiplier (box width, x, y).
// A final byte with no node, or a dropped node, goes straight to the result
// load step. The result sits in an output
// register; in_ready stays low until a finished result has been loaded
// there, so a stalled receiver holds the block once a second result is
// ready. Reset clears the line state, node count and stack fill and loads
// the register defaults; the final byte returns the source state to reset.
`timescale 1ns / 1ps

module indent_outline_tree_builder (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_ch,
  input  logic                              in_last_byte,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_node_valid,
  output logic [iotb_pkg::IDX_W-1:0]        out_node_index,
  output logic [iotb_pkg::DEPTH_W-1:0]      out_depth,
  output logic                              out_has_parent,
  output logic [iotb_pkg::IDX_W-1:0]        out_parent_index,
  output logic [iotb_pkg::LABEL_W-1:0]      out_label_length,
  output logic [iotb_pkg::BW_W-1:0]         out_box_width,
  output logic [iotb_pkg::PX_W-1:0]         out_pos_x,
  output logic [iotb_pkg::PY_W-1:0]         out_pos_y,
  output logic                              out_end_of_source,
  output logic                              out_empty_source,
  output logic                              out_dropped,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [4:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import iotb_pkg::*;

  // Configuration registers
  logic [9:0] hspace_r;
  logic [7:0] vspace_r;
  logic [7:0] margin_r;
  logic [9:0] minbw_r;
  logic [4:0] charw_r;
  logic [2:0] reg_idx;

  // Sequencer state
  iotb_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   ncount_r, ncount_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W-1:0]   job_idx_r, job_idx_nxt;
  logic [DEPTH_W-1:0] job_depth_r, job_depth_nxt;
  logic [LABEL_W-1:0] job_label_r, job_label_nxt;
  logic               job_node_r, job_node_nxt;
  logic               job_drop_r, job_drop_nxt;
  logic               job_last_r, job_last_nxt;
  logic               par_r, par_nxt;
  logic [IDX_W-1:0]   par_idx_r, par_idx_nxt;
  logic [BW_W-1:0]    bw_r, bw_nxt;
  logic [PX_W-1:0]    px_r, px_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               o_node_r;
  logic [IDX_W-1:0]   o_idx_r;
  logic [DEPTH_W-1:0] o_depth_r;
  logic               o_par_r;
  logic [IDX_W-1:0]   o_par_idx_r;
  logic [LABEL_W-1:0] o_label_r;
  logic [BW_W-1:0]    o_bw_r;
  logic [PX_W-1:0]    o_px_r;
  logic [PY_W-1:0]    o_py_r;
  logic               o_eos_r;
  logic               o_empty_r;
  logic               o_drop_r;

  // Datapath links
  line_evt_t              evt;
  stk_ctrl_t              sctrl;
  stk_entry_t             rd_entry;
  logic                   take;
  logic                   mul_en;
  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W:0]        sum_xy;
  logic [PY_W-1:0]        py_val;
  logic                   out_load;
  logic                   out_free;

  assign take     = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign reg_idx  = paddr[4:2];
  assign pready   = 1'b1;

  iotb_line u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .ch        (in_ch),
    .last_byte (in_last_byte),
    .evt       (evt)
  );

  iotb_stack u_stack (
    .clk       (clk),
    .ctrl      (sctrl),
    .rd_data_r (rd_entry)
  );

  iotb_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hspace_r <= 10'd180;
      vspace_r <= 8'd50;
      margin_r <= 8'd20;
      minbw_r  <= 10'd80;
      charw_r  <= 5'd8;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_HSPACE: hspace_r <= pwdata[9:0];
        REG_VSPACE: vspace_r <= pwdata[7:0];
        REG_MARGIN: margin_r <= pwdata[7:0];
        REG_MINBW:  minbw_r  <= pwdata[9:0];
        REG_CHARW:  charw_r  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      REG_HSPACE: prdata = {22'd0, hspace_r};
      REG_VSPACE: prdata = {24'd0, vspace_r};
      REG_MARGIN: prdata = {24'd0, margin_r};
      REG_MINBW:  prdata = {22'd0, minbw_r};
      REG_CHARW:  prdata = {27'd0, charw_r};
      default:    prdata = 32'd0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (evt.line_end && evt.node_found && ncount_r < CNT_W'(MAX_NODES)) begin
            state_nxt = ST_POP_RD;
          end else if ((evt.line_end && evt.node_found) || in_last_byte) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_POP_RD: begin
        state_nxt = (fill_r == '0) ? ST_MUL_BW : ST_POP_CMP;
      end
      ST_POP_CMP: begin
        state_nxt = (rd_entry.level >= job_depth_r) ? ST_POP_RD : ST_MUL_BW;
      end
      ST_MUL_BW: state_nxt = ST_MUL_PX;
      ST_MUL_PX: state_nxt = ST_MUL_PY;
      ST_MUL_PY: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates
  always_comb begin
    ncount_nxt    = ncount_r;
    fill_nxt      = fill_r;
    job_idx_nxt   = job_idx_r;
    job_depth_nxt = job_depth_r;
    job_label_nxt = job_label_r;
    job_node_nxt  = job_node_r;
    job_drop_nxt  = job_drop_r;
    job_last_nxt  = job_last_r;
    par_nxt       = par_r;
    par_idx_nxt   = par_idx_r;
    bw_nxt        = bw_r;
    px_nxt        = px_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    sctrl         = '0;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    sum_xy        = {{(PROD_W-7){1'b0}}, margin_r} + {1'b0, prod};
    py_val        = (sum_xy > (PROD_W+1)'(2**PY_W - 1)) ? PY_W'(2**PY_W - 1)
                                                         : sum_xy[PY_W-1:0];
    sctrl.wr_entry = '{level: job_depth_r, node: job_idx_r};
    sctrl.wr_addr  = fill_r[SADDR_W-1:0];
    sctrl.rd_addr  = SADDR_W'(fill_r - 1'b1);
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          // Capture the finished line
          job_idx_nxt   = ncount_r[IDX_W-1:0];
          job_depth_nxt = evt.depth;
          job_label_nxt = evt.label;
          job_last_nxt  = in_last_byte;
          job_node_nxt  = 1'b0;
          job_drop_nxt  = 1'b0;
          par_nxt       = 1'b0;
          par_idx_nxt   = '0;
          if (evt.line_end && evt.node_found) begin
            if (ncount_r < CNT_W'(MAX_NODES)) begin
              job_node_nxt = 1'b1;
              ncount_nxt   = ncount_r + 1'b1;
            end else begin
              job_drop_nxt = 1'b1;
            end
          end
        end
      end
      ST_POP_RD: begin
        if (fill_r == '0) begin
          // Empty stack: push as a root
          sctrl.wr_en = 1'b1;
          fill_nxt    = fill_r + 1'b1;
        end else begin
          sctrl.rd_en = 1'b1;
        end
      end
      ST_POP_CMP: begin
        if (rd_entry.level >= job_depth_r) begin
          // Drop entries that are not shallower
          fill_nxt = fill_r - 1'b1;
        end else begin
          par_nxt     = 1'b1;
          par_idx_nxt = rd_entry.node;
          if (fill_r < FILL_W'(STACK_SIZE)) begin
            sctrl.wr_en = 1'b1;
            fill_nxt    = fill_r + 1'b1;
          end
        end
      end
      ST_MUL_BW: begin
        mul_en = 1'b1;
        mul_a  = job_label_r;
        mul_b  = MUL_B_W'(charw_r);
      end
      ST_MUL_PX: begin
        // Box width from the product, then start the x product
        if (prod > PROD_W'(2**BW_W - 1)) begin
          bw_nxt = BW_W'(2**BW_W - 1);
        end else begin
          bw_nxt = prod[BW_W-1:0];
        end
        if (bw_nxt < BW_W'(minbw_r)) begin
          bw_nxt = BW_W'(minbw_r);
        end
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(job_depth_r);
        mul_b  = hspace_r;
      end
      ST_MUL_PY: begin
        if (sum_xy > (PROD_W+1)'(2**PX_W - 1)) begin
          px_nxt = PX_W'(2**PX_W - 1);
        end else begin
          px_nxt = sum_xy[PX_W-1:0];
        end
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(job_idx_r);
        mul_b  = MUL_B_W'(vspace_r);
      end
      ST_DONE: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          // Final byte: return the source state to reset
          if (job_last_r) begin
            ncount_nxt = '0;
            fill_nxt   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ncount_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ncount_r    <= ncount_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Job payload registers
  always_ff @(posedge clk) begin
    job_idx_r   <= job_idx_nxt;
    job_depth_r <= job_depth_nxt;
    job_label_r <= job_label_nxt;
    job_node_r  <= job_node_nxt;
    job_drop_r  <= job_drop_nxt;
    job_last_r  <= job_last_nxt;
    par_r       <= par_nxt;
    par_idx_r   <= par_idx_nxt;
    bw_r        <= bw_nxt;
    px_r        <= px_nxt;
  end

  // Load the result word; node fields stay zero without a stored node
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_node_r    <= job_node_r;
      o_idx_r     <= job_node_r ? job_idx_r : '0;
      o_depth_r   <= job_node_r ? job_depth_r : '0;
      o_par_r     <= job_node_r && par_r;
      o_par_idx_r <= (job_node_r && par_r) ? par_idx_r : '0;
      o_label_r   <= job_node_r ? job_label_r : '0;
      o_bw_r      <= job_node_r ? bw_r : '0;
      o_px_r      <= job_node_r ? px_r : '0;
      o_py_r      <= job_node_r ? py_val : '0;
      o_eos_r     <= job_last_r;
      o_empty_r   <= job_last_r && (ncount_r == '0);
      o_drop_r    <= job_drop_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_node_valid    = o_node_r;
  assign out_node_index    = o_idx_r;
  assign out_depth         = o_depth_r;
  assign out_has_parent    = o_par_r;
  assign out_parent_index  = o_par_idx_r;
  assign out_label_length  = o_label_r;
  assign out_box_width     = o_bw_r;
  assign out_pos_x         = o_px_r;
  assign out_pos_y         = o_py_r;
  assign out_end_of_source = o_eos_r;
  assign out_empty_source  = o_empty_r;
  assign out_dropped       = o_drop_r;

endmodule

/* rtl/iotb_line.sv */
// Line decoder: indentation counting and label length for the current line.
`timescale 1ns / 1ps

module iotb_line (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        ch,
  input  logic              last_byte,
  output iotb_pkg::line_evt_t evt
);
  import iotb_pkg::*;

  logic               in_indent_r, in_indent_nxt;
  logic               pend_r, pend_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [LABEL_W-1:0] label_r, label_nxt;
  logic [1:0]         inc;
  logic [LABEL_W:0]   lab_sum;
  logic [LABEL_W-1:0] lab_sat;
  logic [DEPTH_W-1:0] depth_up;
  logic               line_end;

  // Decode the byte against the line state
  always_comb begin
    depth_up      = (depth_r < DEPTH_W'(MAX_DEPTH)) ? depth_r + 1'b1 : depth_r;
    in_indent_nxt = in_indent_r;
    pend_nxt      = pend_r;
    depth_nxt     = depth_r;
    inc           = 2'd0;
    line_end      = (ch == CH_NL) || last_byte;
    if (ch != CH_NL) begin
      if (in_indent_r) begin
        if (ch == CH_TAB && !pend_r) begin
          depth_nxt = depth_up;
        end else if (ch == CH_SPACE) begin
          if (pend_r) begin
            depth_nxt = depth_up;
            pend_nxt  = 1'b0;
          end else begin
            pend_nxt = 1'b1;
          end
        end else begin
          in_indent_nxt = 1'b0;
          pend_nxt      = 1'b0;
          inc           = pend_r ? 2'd2 : 2'd1;
        end
      end else begin
        inc = 2'd1;
      end
    end
    // A lone space left at line end counts as a label byte
    if (line_end && in_indent_nxt && pend_nxt) begin
      inc = 2'd1;
    end
    lab_sum = {1'b0, label_r} + {{(LABEL_W-1){1'b0}}, inc};
    lab_sat = (lab_sum > (LABEL_W+1)'(LABEL_MAX)) ? LABEL_W'(LABEL_MAX)
                                                   : lab_sum[LABEL_W-1:0];
    label_nxt = lab_sat;

    evt.line_end   = line_end;
    evt.node_found = (lab_sat != '0);
    evt.label      = lab_sat;
    evt.depth      = depth_nxt;
  end

  // Advance the line state, restart it at line end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_indent_r <= 1'b1;
      pend_r      <= 1'b0;
      depth_r     <= '0;
      label_r     <= '0;
    end else if (take) begin
      if (line_end) begin
        in_indent_r <= 1'b1;
        pend_r      <= 1'b0;
        depth_r     <= '0;
        label_r     <= '0;
      end else begin
        in_indent_r <= in_indent_nxt;
        pend_r      <= pend_nxt;
        depth_r     <= depth_nxt;
        label_r     <= label_nxt;
      end
    end
  end

endmodule

/* rtl/iotb_stack.sv */
// Ancestor stack memory: one write port, one registered read port.
`timescale 1ns / 1ps

module iotb_stack (
  input  logic                  clk,
  input  iotb_pkg::stk_ctrl_t   ctrl,
  output iotb_pkg::stk_entry_t  rd_data_r
);
  import iotb_pkg::*;

  stk_entry_t mem [STACK_SIZE];

  // Write the pushed entry
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_entry;
    end
  end

  // Read the top of the stack
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data_r <= mem[ctrl.rd_addr];
    end
  end

endmodule

/* rtl/iotb_mul.sv */
// Shared multiplier with registered product, used for width and both positions.
`timescale 1ns / 1ps

module iotb_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic [iotb_pkg::MUL_A_W-1:0]  op_a,
  input  logic [iotb_pkg::MUL_B_W-1:0]  op_b,
  output logic [iotb_pkg::PROD_W-1:0]   prod_r
);
  import iotb_pkg::*;

  // Hold the product while the sequencer is not multiplying
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

endmodule
